>>> src/gn2f_pkg.sv
// shared types, constants and command structs for the 2d gradient noise fbm block
// used by gn2f_ctrl, gn2f_datapath and gradient_noise_2d_fbm_top; no dependencies

package gn2f_pkg;

    // default parameter values
    localparam int TABLE_SIZE_DEF  = 256;
    localparam int MAX_OCTAVES_DEF = 16;
    localparam int FRAC_BITS_DEF   = 16;

    // fixed field widths
    localparam int ACTION_W   = 2;
    localparam int INDEX_W    = 8;
    localparam int PERM_W     = 8;
    localparam int GRAD_W     = 16;
    localparam int GRAD_FRAC  = 14;
    localparam int COORD_W    = 32;
    localparam int NOISE_W    = 32;
    localparam int OCT_CFG_W  = 5;
    localparam int FREQ_W     = 24;
    localparam int AMP_W      = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    // register reset values
    localparam logic [OCT_CFG_W-1:0] OCT_RST  = 5'd1;
    localparam logic [FREQ_W-1:0]    FREQ_RST = 24'd1114;
    localparam logic [AMP_W-1:0]     AMP_RST  = 24'd65536;

    // word actions
    typedef enum logic [ACTION_W-1:0] {
        ACT_LOAD_PERM = 2'd0,
        ACT_LOAD_GRAD = 2'd1,
        ACT_EVAL      = 2'd2
    } t_action;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OCTAVE_COUNT = 2'd0,
        CFG_FREQUENCY    = 2'd1,
        CFG_AMPLITUDE    = 2'd2
    } t_cfg_reg;

    // controller states, fourteen steps per octave
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SCALE_X,
        ST_SCALE_Y,
        ST_O00,
        ST_O01,
        ST_O02,
        ST_O03,
        ST_O04,
        ST_O05,
        ST_O06,
        ST_O07,
        ST_O08,
        ST_O09,
        ST_O10,
        ST_O11,
        ST_O12,
        ST_O13,
        ST_FINISH
    } t_state;

    // permutation read address source
    typedef enum logic [2:0] {
        PS_BX0,
        PS_BX1,
        PS_IY0,
        PS_JY0,
        PS_IY1,
        PS_JY1
    } t_perm_sel;

    // lattice corner, bit 0 is the x side, bit 1 the y side
    typedef enum logic [1:0] {
        C00 = 2'd0,
        C10 = 2'd1,
        C01 = 2'd2,
        C11 = 2'd3
    } t_corner;

    // shared multiplier operand selection
    typedef enum logic [2:0] {
        MUL_TT_X,
        MUL_SS_X,
        MUL_TT_Y,
        MUL_SS_Y,
        MUL_LERP_A,
        MUL_LERP_B,
        MUL_LERP_N,
        MUL_AMP
    } t_mul_sel;

    // controller to datapath
    typedef struct packed {
        logic      accept;
        logic      load_ack;
        logic      scale_x;
        logic      scale_y;
        t_perm_sel perm_sel;
        logic      latch_i;
        logic      latch_j;
        logic      latch_sx;
        logic      latch_sy;
        logic      dot_we;
        t_corner   corner;
        t_mul_sel  mul_sel;
        logic      latch_a;
        logic      latch_b;
        logic      latch_n;
        logic      accum;
        logic      finish;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;
        logic no_octaves;
        logic last_octave;
    } t_dp_status;

endpackage

>>> src/gradient_noise_2d_fbm_top.sv
// Two-dimensional Perlin gradient noise summed over octaves, in fixed point.
// Load words write one permutation or gradient entry and are acknowledged with a
// zero word in the cycle after acceptance. An evaluate word sums N octaves, N
// being the octave count limited to MAX_OCTAVES; the next word is taken no sooner
// than the cycle after the result is loaded. Each octave is fourteen steps of a
// sequencer around one shared multiplier and permutation and gradient tables with
// a write and a registered read port each. Tables hold no reset value; the user
// must write configuration only while idle; the block itself does not enforce it.
// depends on gn2f_pkg, gn2f_ctrl and gn2f_datapath

module gradient_noise_2d_fbm_top #(
    parameter int TABLE_SIZE  = gn2f_pkg::TABLE_SIZE_DEF,
    parameter int MAX_OCTAVES = gn2f_pkg::MAX_OCTAVES_DEF,
    parameter int FRAC_BITS   = gn2f_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [gn2f_pkg::ACTION_W-1:0]       i_action,
    input  logic [gn2f_pkg::INDEX_W-1:0]        i_index,
    input  logic [gn2f_pkg::PERM_W-1:0]         i_perm_value,
    input  logic signed [gn2f_pkg::GRAD_W-1:0]  i_grad_x,
    input  logic signed [gn2f_pkg::GRAD_W-1:0]  i_grad_y,
    input  logic signed [gn2f_pkg::COORD_W-1:0] i_coord_x,
    input  logic signed [gn2f_pkg::COORD_W-1:0] i_coord_y,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [gn2f_pkg::NOISE_W-1:0] o_noise_value,
    output logic                                o_is_noise,
    input  logic                                i_cfg_we,
    input  logic [gn2f_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [gn2f_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    gn2f_pkg::t_dp_cmd    dp_cmd;
    gn2f_pkg::t_dp_status dp_status;

    // sequencer
    gn2f_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_action (i_action),
        .i_status (dp_status),
        .o_ready  (o_ready),
        .o_cmd    (dp_cmd)
    );

    // tables and arithmetic
    gn2f_datapath #(
        .TABLE_SIZE  (TABLE_SIZE),
        .MAX_OCTAVES (MAX_OCTAVES),
        .FRAC_BITS   (FRAC_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_status      (dp_status),
        .i_action      (i_action),
        .i_index       (i_index),
        .i_perm_value  (i_perm_value),
        .i_grad_x      (i_grad_x),
        .i_grad_y      (i_grad_y),
        .i_coord_x     (i_coord_x),
        .i_coord_y     (i_coord_y),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_ready       (i_ready),
        .o_valid       (o_valid),
        .o_noise_value (o_noise_value),
        .o_is_noise    (o_is_noise)
    );

`ifndef SYNTH
    // a load word is acknowledged in the next cycle
    a_load_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && (i_action != gn2f_pkg::ACT_EVAL)) |=> (o_valid && !o_is_noise))
        else $error("load word not acknowledged");

    // ready drops once an evaluate word is taken
    a_eval_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && (i_action == gn2f_pkg::ACT_EVAL)) |=> !o_ready)
        else $error("word taken during evaluation");

    // acknowledges carry a zero value
    a_ack_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_is_noise) |-> (o_noise_value == '0))
        else $error("load acknowledge with non-zero value");
`endif

endmodule

>>> src/gn2f_ctrl.sv
// controller state machine for the 2d gradient noise fbm block
// depends on gn2f_pkg; drives gn2f_datapath through t_dp_cmd

module gn2f_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [gn2f_pkg::ACTION_W-1:0] i_action,
    input  gn2f_pkg::t_dp_status          i_status,
    output logic                          o_ready,
    output gn2f_pkg::t_dp_cmd             o_cmd
);

    gn2f_pkg::t_state r_state;
    gn2f_pkg::t_state n_state;
    logic             accept;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gn2f_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // handshake, a load needs the output register free for its ack
    assign o_ready = (r_state == gn2f_pkg::ST_IDLE) && i_status.out_free;
    assign accept  = i_valid && o_ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gn2f_pkg::ST_IDLE: begin
                if (accept && (i_action == gn2f_pkg::ACT_EVAL)) n_state = gn2f_pkg::ST_SCALE_X;
            end
            gn2f_pkg::ST_SCALE_X: n_state = gn2f_pkg::ST_SCALE_Y;
            gn2f_pkg::ST_SCALE_Y: begin
                n_state = i_status.no_octaves ? gn2f_pkg::ST_FINISH : gn2f_pkg::ST_O00;
            end
            gn2f_pkg::ST_O00: n_state = gn2f_pkg::ST_O01;
            gn2f_pkg::ST_O01: n_state = gn2f_pkg::ST_O02;
            gn2f_pkg::ST_O02: n_state = gn2f_pkg::ST_O03;
            gn2f_pkg::ST_O03: n_state = gn2f_pkg::ST_O04;
            gn2f_pkg::ST_O04: n_state = gn2f_pkg::ST_O05;
            gn2f_pkg::ST_O05: n_state = gn2f_pkg::ST_O06;
            gn2f_pkg::ST_O06: n_state = gn2f_pkg::ST_O07;
            gn2f_pkg::ST_O07: n_state = gn2f_pkg::ST_O08;
            gn2f_pkg::ST_O08: n_state = gn2f_pkg::ST_O09;
            gn2f_pkg::ST_O09: n_state = gn2f_pkg::ST_O10;
            gn2f_pkg::ST_O10: n_state = gn2f_pkg::ST_O11;
            gn2f_pkg::ST_O11: n_state = gn2f_pkg::ST_O12;
            gn2f_pkg::ST_O12: n_state = gn2f_pkg::ST_O13;
            gn2f_pkg::ST_O13: begin
                n_state = i_status.last_octave ? gn2f_pkg::ST_FINISH : gn2f_pkg::ST_O00;
            end
            gn2f_pkg::ST_FINISH: begin
                if (i_status.out_free) n_state = gn2f_pkg::ST_IDLE;
            end
            default: n_state = gn2f_pkg::ST_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd          = '0;
        o_cmd.accept   = accept;
        o_cmd.load_ack = accept && (i_action != gn2f_pkg::ACT_EVAL);
        unique case (r_state)
            gn2f_pkg::ST_IDLE: begin
            end
            gn2f_pkg::ST_SCALE_X: o_cmd.scale_x = 1'b1;
            gn2f_pkg::ST_SCALE_Y: o_cmd.scale_y = 1'b1;
            // hash reads and smooth step of both fractions
            gn2f_pkg::ST_O00: begin
                o_cmd.perm_sel = gn2f_pkg::PS_BX0;
                o_cmd.mul_sel  = gn2f_pkg::MUL_TT_X;
            end
            gn2f_pkg::ST_O01: begin
                o_cmd.perm_sel = gn2f_pkg::PS_BX1;
                o_cmd.latch_i  = 1'b1;
                o_cmd.mul_sel  = gn2f_pkg::MUL_SS_X;
            end
            gn2f_pkg::ST_O02: begin
                o_cmd.perm_sel = gn2f_pkg::PS_IY0;
                o_cmd.latch_j  = 1'b1;
                o_cmd.latch_sx = 1'b1;
                o_cmd.mul_sel  = gn2f_pkg::MUL_TT_Y;
            end
            gn2f_pkg::ST_O03: begin
                o_cmd.perm_sel = gn2f_pkg::PS_JY0;
                o_cmd.mul_sel  = gn2f_pkg::MUL_SS_Y;
            end
            // corner dot products as gradients arrive
            gn2f_pkg::ST_O04: begin
                o_cmd.perm_sel = gn2f_pkg::PS_IY1;
                o_cmd.dot_we   = 1'b1;
                o_cmd.corner   = gn2f_pkg::C00;
                o_cmd.latch_sy = 1'b1;
            end
            gn2f_pkg::ST_O05: begin
                o_cmd.perm_sel = gn2f_pkg::PS_JY1;
                o_cmd.dot_we   = 1'b1;
                o_cmd.corner   = gn2f_pkg::C10;
            end
            gn2f_pkg::ST_O06: begin
                o_cmd.dot_we  = 1'b1;
                o_cmd.corner  = gn2f_pkg::C01;
                o_cmd.mul_sel = gn2f_pkg::MUL_LERP_A;
            end
            gn2f_pkg::ST_O07: begin
                o_cmd.dot_we  = 1'b1;
                o_cmd.corner  = gn2f_pkg::C11;
                o_cmd.latch_a = 1'b1;
            end
            // blends, weighting and accumulation
            gn2f_pkg::ST_O08: o_cmd.mul_sel = gn2f_pkg::MUL_LERP_B;
            gn2f_pkg::ST_O09: o_cmd.latch_b = 1'b1;
            gn2f_pkg::ST_O10: o_cmd.mul_sel = gn2f_pkg::MUL_LERP_N;
            gn2f_pkg::ST_O11: o_cmd.latch_n = 1'b1;
            gn2f_pkg::ST_O12: o_cmd.mul_sel = gn2f_pkg::MUL_AMP;
            gn2f_pkg::ST_O13: o_cmd.accum   = 1'b1;
            gn2f_pkg::ST_FINISH: o_cmd.finish = i_status.out_free;
            default: begin
            end
        endcase
    end

endmodule

>>> src/gn2f_datapath.sv
// datapath for the 2d gradient noise fbm block: tables, multipliers, accumulator
// depends on gn2f_pkg; controlled by gn2f_ctrl through t_dp_cmd

module gn2f_datapath #(
    parameter int TABLE_SIZE  = gn2f_pkg::TABLE_SIZE_DEF,
    parameter int MAX_OCTAVES = gn2f_pkg::MAX_OCTAVES_DEF,
    parameter int FRAC_BITS   = gn2f_pkg::FRAC_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  gn2f_pkg::t_dp_cmd                      i_cmd,
    output gn2f_pkg::t_dp_status                   o_status,
    input  logic [gn2f_pkg::ACTION_W-1:0]          i_action,
    input  logic [gn2f_pkg::INDEX_W-1:0]           i_index,
    input  logic [gn2f_pkg::PERM_W-1:0]            i_perm_value,
    input  logic signed [gn2f_pkg::GRAD_W-1:0]     i_grad_x,
    input  logic signed [gn2f_pkg::GRAD_W-1:0]     i_grad_y,
    input  logic signed [gn2f_pkg::COORD_W-1:0]    i_coord_x,
    input  logic signed [gn2f_pkg::COORD_W-1:0]    i_coord_y,
    input  logic                                   i_cfg_we,
    input  logic [gn2f_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [gn2f_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                                   i_ready,
    output logic                                   o_valid,
    output logic signed [gn2f_pkg::NOISE_W-1:0]    o_noise_value,
    output logic                                   o_is_noise
);

    localparam int F   = FRAC_BITS;
    localparam int L   = $clog2(TABLE_SIZE);
    localparam int PW  = F + L;
    localparam int OCW = $clog2(MAX_OCTAVES + 1);
    localparam int GW  = gn2f_pkg::GRAD_W;
    localparam int DW  = F + GW + 2 - gn2f_pkg::GRAD_FRAC;
    localparam int MA  = DW + 1;
    localparam int MB  = (F + 3 > gn2f_pkg::AMP_W + 1) ? F + 3 : gn2f_pkg::AMP_W + 1;
    localparam int MP  = MA + MB;
    localparam int AW  = MP - F + 6;
    localparam int SPW = gn2f_pkg::COORD_W + gn2f_pkg::FREQ_W + 1;
    localparam int XW  = (F + PW > SPW) ? F + PW : SPW;
    localparam int PV  = gn2f_pkg::PERM_W;
    localparam int NW  = gn2f_pkg::NOISE_W;
    localparam logic [F+2:0] THREE_ONE = (F + 3)'(3) << F;
    localparam logic signed [AW-1:0] SAT_HI = AW'(signed'({1'b0, {(NW-1){1'b1}}}));
    localparam logic signed [AW-1:0] SAT_LO = AW'(signed'({1'b1, {(NW-1){1'b0}}}));

    // configuration registers
    logic [gn2f_pkg::OCT_CFG_W-1:0] r_oct_cfg;
    logic [gn2f_pkg::FREQ_W-1:0]    r_freq;
    logic [gn2f_pkg::AMP_W-1:0]     r_amp_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oct_cfg <= gn2f_pkg::OCT_RST;
            r_freq    <= gn2f_pkg::FREQ_RST;
            r_amp_cfg <= gn2f_pkg::AMP_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                gn2f_pkg::CFG_OCTAVE_COUNT: r_oct_cfg <= i_cfg_data[gn2f_pkg::OCT_CFG_W-1:0];
                gn2f_pkg::CFG_FREQUENCY:    r_freq    <= i_cfg_data[gn2f_pkg::FREQ_W-1:0];
                gn2f_pkg::CFG_AMPLITUDE:    r_amp_cfg <= i_cfg_data[gn2f_pkg::AMP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // working registers
    logic signed [gn2f_pkg::COORD_W-1:0] r_cx;
    logic signed [gn2f_pkg::COORD_W-1:0] r_cy;
    logic [PW-1:0]                       r_px;
    logic [PW-1:0]                       r_py;
    logic [gn2f_pkg::AMP_W-1:0]          r_amp;
    logic [OCW-1:0]                      r_oct_left;
    logic [PV-1:0]                       r_i;
    logic [PV-1:0]                       r_j;
    logic [PV-1:0]                       r_perm_q;
    logic [2*GW-1:0]                     r_grad_q;
    logic [F:0]                          r_sx;
    logic [F:0]                          r_sy;
    logic signed [DW-1:0]                r_dot [4];
    logic signed [DW-1:0]                r_a;
    logic signed [DW-1:0]                r_b;
    logic signed [DW-1:0]                r_n;
    logic signed [MP-1:0]                r_prod;
    logic signed [AW-1:0]                r_sum;
    logic                                r_out_valid;
    logic signed [NW-1:0]                r_out_value;
    logic                                r_out_is_noise;

    // table memories
    logic [PV-1:0]   mem_perm [TABLE_SIZE];
    logic [2*GW-1:0] mem_grad [TABLE_SIZE];

    logic [L+gn2f_pkg::INDEX_W-1:0] idx_wide;
    logic [L-1:0]                   wr_idx;
    logic [L+PV-1:0]                i_wide;
    logic [L+PV-1:0]                j_wide;
    logic [L+PV-1:0]                q_wide;
    logic [L-1:0]                   i_l;
    logic [L-1:0]                   j_l;
    logic [L-1:0]                   grad_addr;
    logic [L-1:0]                   bx0;
    logic [L-1:0]                   bx1;
    logic [L-1:0]                   by0;
    logic [L-1:0]                   by1;
    logic [L-1:0]                   perm_addr;

    assign idx_wide  = {{L{1'b0}}, i_index};
    assign wr_idx    = idx_wide[L-1:0];
    assign i_wide    = {{L{1'b0}}, r_i};
    assign j_wide    = {{L{1'b0}}, r_j};
    assign q_wide    = {{L{1'b0}}, r_perm_q};
    assign i_l       = i_wide[L-1:0];
    assign j_l       = j_wide[L-1:0];
    assign grad_addr = q_wide[L-1:0];
    assign bx0       = r_px[F +: L];
    assign by0       = r_py[F +: L];
    assign bx1       = bx0 + 1'b1;
    assign by1       = by0 + 1'b1;

    // permutation read address
    always_comb begin
        case (i_cmd.perm_sel)
            gn2f_pkg::PS_BX0: perm_addr = bx0;
            gn2f_pkg::PS_BX1: perm_addr = bx1;
            gn2f_pkg::PS_IY0: perm_addr = i_l + by0;
            gn2f_pkg::PS_JY0: perm_addr = j_l + by0;
            gn2f_pkg::PS_IY1: perm_addr = i_l + by1;
            gn2f_pkg::PS_JY1: perm_addr = j_l + by1;
            default:          perm_addr = bx0;
        endcase
    end

    // permutation table, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_ack && (i_action == gn2f_pkg::ACT_LOAD_PERM)) begin
            mem_perm[wr_idx] <= i_perm_value;
        end
        r_perm_q <= mem_perm[perm_addr];
    end

    // gradient table, addressed by the last hash read
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_ack && (i_action == gn2f_pkg::ACT_LOAD_GRAD)) begin
            mem_grad[wr_idx] <= {i_grad_x, i_grad_y};
        end
        r_grad_q <= mem_grad[grad_addr];
    end

    // coordinate scaling, one axis a cycle
    logic signed [gn2f_pkg::COORD_W-1:0] scale_in;
    logic signed [SPW-1:0]               scale_prod;
    logic signed [XW-1:0]                scale_ext;

    assign scale_in   = i_cmd.scale_x ? r_cx : r_cy;
    assign scale_prod = scale_in * signed'({1'b0, r_freq});
    assign scale_ext  = XW'(scale_prod);

    // corner dot product from the gradient word
    logic [F-1:0]              tx;
    logic [F-1:0]              ty;
    logic [1:0]                corner_bits;
    logic signed [F:0]         rx;
    logic signed [F:0]         ry;
    logic signed [GW-1:0]      gx;
    logic signed [GW-1:0]      gy;
    logic signed [F+GW:0]      px_g;
    logic signed [F+GW:0]      py_g;
    logic signed [F+GW+1:0]    dot_sum;
    logic signed [DW-1:0]      dot_val;

    assign tx          = r_px[F-1:0];
    assign ty          = r_py[F-1:0];
    assign corner_bits = i_cmd.corner;
    assign rx          = signed'({corner_bits[0], tx});
    assign ry          = signed'({corner_bits[1], ty});
    assign gx          = signed'(r_grad_q[2*GW-1:GW]);
    assign gy          = signed'(r_grad_q[GW-1:0]);
    assign px_g        = rx * gx;
    assign py_g        = ry * gy;
    assign dot_sum     = (F + GW + 2)'(px_g) + (F + GW + 2)'(py_g);
    assign dot_val     = dot_sum[F+GW+1:gn2f_pkg::GRAD_FRAC];

    // shared multiplier operands
    logic signed [MA-1:0] mul_a;
    logic signed [MB-1:0] mul_b;
    logic [F-1:0]         t2;

    assign t2 = r_prod[2*F-1:F];

    always_comb begin
        case (i_cmd.mul_sel)
            gn2f_pkg::MUL_TT_X: begin
                mul_a = MA'(signed'({1'b0, tx}));
                mul_b = MB'(signed'({1'b0, tx}));
            end
            gn2f_pkg::MUL_SS_X: begin
                mul_a = MA'(signed'({1'b0, t2}));
                mul_b = MB'(signed'(THREE_ONE - {1'b0, tx, 1'b0}));
            end
            gn2f_pkg::MUL_TT_Y: begin
                mul_a = MA'(signed'({1'b0, ty}));
                mul_b = MB'(signed'({1'b0, ty}));
            end
            gn2f_pkg::MUL_SS_Y: begin
                mul_a = MA'(signed'({1'b0, t2}));
                mul_b = MB'(signed'(THREE_ONE - {1'b0, ty, 1'b0}));
            end
            gn2f_pkg::MUL_LERP_A: begin
                mul_a = MA'(r_dot[gn2f_pkg::C10]) - MA'(r_dot[gn2f_pkg::C00]);
                mul_b = MB'(signed'({1'b0, r_sx}));
            end
            gn2f_pkg::MUL_LERP_B: begin
                mul_a = MA'(r_dot[gn2f_pkg::C11]) - MA'(r_dot[gn2f_pkg::C01]);
                mul_b = MB'(signed'({1'b0, r_sx}));
            end
            gn2f_pkg::MUL_LERP_N: begin
                mul_a = MA'(r_b) - MA'(r_a);
                mul_b = MB'(signed'({1'b0, r_sy}));
            end
            gn2f_pkg::MUL_AMP: begin
                mul_a = MA'(r_n);
                mul_b = MB'(signed'({1'b0, r_amp}));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // blend result: base plus floored scaled difference
    logic signed [DW-1:0] lerp_base;
    logic signed [DW:0]   lerp_q;
    logic signed [DW:0]   lerp_sum;
    logic signed [DW-1:0] lerp_res;
    logic signed [AW-1:0] term;

    always_comb begin
        if (i_cmd.latch_a) begin
            lerp_base = r_dot[gn2f_pkg::C00];
        end else if (i_cmd.latch_b) begin
            lerp_base = r_dot[gn2f_pkg::C01];
        end else begin
            lerp_base = r_a;
        end
    end

    assign lerp_q   = signed'(r_prod[F+DW:F]);
    assign lerp_sum = (DW + 1)'(lerp_base) + lerp_q;
    assign lerp_res = lerp_sum[DW-1:0];
    assign term     = AW'(signed'(r_prod[MP-1:F]));

    // octave limit
    logic [5:0]     oct_ext;
    logic [OCW-1:0] oct_load;

    assign oct_ext  = {1'b0, r_oct_cfg};
    assign oct_load = (oct_ext > 6'(MAX_OCTAVES)) ? OCW'(MAX_OCTAVES) : OCW'(oct_ext);

    // octave counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oct_left <= '0;
        end else if (i_cmd.accept) begin
            r_oct_left <= oct_load;
        end else if (i_cmd.accum) begin
            r_oct_left <= r_oct_left - 1'b1;
        end
    end

    // arithmetic pipeline registers
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (i_cmd.accept) begin
            r_cx  <= i_coord_x;
            r_cy  <= i_coord_y;
            r_amp <= r_amp_cfg;
            r_sum <= '0;
        end
        if (i_cmd.scale_x) r_px <= scale_ext[F +: PW];
        if (i_cmd.scale_y) r_py <= scale_ext[F +: PW];
        if (i_cmd.latch_i) r_i <= r_perm_q;
        if (i_cmd.latch_j) r_j <= r_perm_q;
        if (i_cmd.latch_sx) r_sx <= r_prod[2*F:F];
        if (i_cmd.latch_sy) r_sy <= r_prod[2*F:F];
        if (i_cmd.dot_we) r_dot[i_cmd.corner] <= dot_val;
        if (i_cmd.latch_a) r_a <= lerp_res;
        if (i_cmd.latch_b) r_b <= lerp_res;
        if (i_cmd.latch_n) r_n <= lerp_res;
        if (i_cmd.accum) begin
            r_sum <= r_sum + term;
            r_px  <= {r_px[PW-2:0], 1'b0};
            r_py  <= {r_py[PW-2:0], 1'b0};
            r_amp <= r_amp >> 1;
        end
    end

    // saturated sum
    logic signed [NW-1:0] sat_val;

    always_comb begin
        if (r_sum > SAT_HI) begin
            sat_val = SAT_HI[NW-1:0];
        end else if (r_sum < SAT_LO) begin
            sat_val = SAT_LO[NW-1:0];
        end else begin
            sat_val = r_sum[NW-1:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_ack || i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_ack) begin
            r_out_value    <= '0;
            r_out_is_noise <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_value    <= sat_val;
            r_out_is_noise <= 1'b1;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_noise_value = r_out_value;
    assign o_is_noise    = r_out_is_noise;

    // status
    assign o_status.out_free    = !r_out_valid || i_ready;
    assign o_status.no_octaves  = (r_oct_left == '0);
    assign o_status.last_octave = (r_oct_left == OCW'(1));

endmodule

>>> sim/testbench.sv
// self-checking testbench for gradient_noise_2d_fbm_top: loads both tables, then
// evaluates points under several register settings and checks every word
// depends on gn2f_pkg and the rtl of the block only

module testbench;
    import gn2f_pkg::*;

    localparam logic [1:0] ACT_SPARE = 2'd3;
    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam int unsigned CYCLE_LIMIT = 1500000;

    typedef struct packed {
        logic signed [NOISE_W-1:0] noise_value;
        logic                      is_noise;
    } t_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic [ACTION_W-1:0] i_action = '0;
    logic [INDEX_W-1:0] i_index = '0;
    logic [PERM_W-1:0] i_perm_value = '0;
    logic signed [GRAD_W-1:0] i_grad_x = '0;
    logic signed [GRAD_W-1:0] i_grad_y = '0;
    logic signed [COORD_W-1:0] i_coord_x = '0;
    logic signed [COORD_W-1:0] i_coord_y = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic signed [NOISE_W-1:0] o_noise_value;
    logic o_is_noise;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // predictor copy of state and registers
    logic [PERM_W-1:0] perm_tab[256];
    logic signed [GRAD_W-1:0] gx_tab[256];
    logic signed [GRAD_W-1:0] gy_tab[256];
    logic [OCT_CFG_W-1:0] octaves_reg = OCT_RST;
    logic [FREQ_W-1:0] freq_reg = FREQ_RST;
    logic [AMP_W-1:0] amp_reg = AMP_RST;

    t_result expected_words[$];
    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;
    bit calm = 1'b0;

    gradient_noise_2d_fbm_top dut (.*);

    // clock
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // smooth step of a fraction
    function automatic longint smooth_step(longint t);
        longint t2;
        t2 = (t * t) >>> 16;
        return (t2 * (3 * 65536 - 2 * t)) >>> 16;
    endfunction

    function automatic longint lerp_q(longint s, longint a, longint b);
        return a + ((s * (b - a)) >>> 16);
    endfunction

    function automatic longint grad_dot(logic [7:0] h, longint rx, longint ry);
        longint gx;
        longint gy;
        gx = gx_tab[h];
        gy = gy_tab[h];
        return (rx * gx + ry * gy) >>> 14;
    endfunction

    // one octave of gradient noise at a scaled point
    function automatic longint octave_noise(logic [63:0] px, logic [63:0] py);
        longint rx0, ry0, rx1, ry1, sx, sy, a, b;
        logic [7:0] bx0, by0, bx1, by1, pi, pj;
        rx0 = longint'(px[15:0]);
        ry0 = longint'(py[15:0]);
        rx1 = rx0 - 65536;
        ry1 = ry0 - 65536;
        bx0 = px[23:16];
        by0 = py[23:16];
        bx1 = bx0 + 8'd1;
        by1 = by0 + 8'd1;
        pi = perm_tab[bx0];
        pj = perm_tab[bx1];
        sx = smooth_step(rx0);
        sy = smooth_step(ry0);
        a = lerp_q(sx, grad_dot(perm_tab[8'(pi + by0)], rx0, ry0),
                   grad_dot(perm_tab[8'(pj + by0)], rx1, ry0));
        b = lerp_q(sx, grad_dot(perm_tab[8'(pi + by1)], rx0, ry1),
                   grad_dot(perm_tab[8'(pj + by1)], rx1, ry1));
        return lerp_q(sy, a, b);
    endfunction

    // fbm sum over the configured octaves, saturated
    function automatic logic signed [31:0] fbm_sum(logic signed [31:0] cx,
                                                   logic signed [31:0] cy);
        longint cxl, cyl, f, amp, sum;
        logic [63:0] px, py;
        int terms;
        cxl = cx;
        cyl = cy;
        f = longint'({40'd0, freq_reg});
        amp = longint'({40'd0, amp_reg});
        px = 64'(cxl * f) >> 16;
        py = 64'(cyl * f) >> 16;
        terms = (octaves_reg > 16) ? 16 : int'(octaves_reg);
        sum = 0;
        for (int k = 0; k < terms; k++) begin
            sum += (octave_noise(px, py) * amp) >>> 16;
            px = px << 1;
            py = py << 1;
            amp = amp >>> 1;
        end
        if (sum > 64'sd2147483647) sum = 64'sd2147483647;
        if (sum < -64'sd2147483648) sum = -64'sd2147483648;
        return 32'(sum);
    endfunction

    // send one word and record what it should produce
    task automatic send_word(logic [1:0] act, logic [7:0] idx, logic [7:0] pv,
                             logic [15:0] gx, logic [15:0] gy,
                             logic [31:0] cx, logic [31:0] cy);
        t_result r;
        if (!calm && $urandom_range(99) < 14) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_action <= act;
        i_index <= idx;
        i_perm_value <= pv;
        i_grad_x <= gx;
        i_grad_y <= gy;
        i_coord_x <= cx;
        i_coord_y <= cy;
        do @(posedge i_clk); while (!o_ready);
        r.noise_value = '0;
        r.is_noise = 1'b0;
        case (act)
            ACT_LOAD_PERM: perm_tab[idx] = pv;
            ACT_LOAD_GRAD: begin
                gx_tab[idx] = gx;
                gy_tab[idx] = gy;
            end
            ACT_EVAL: begin
                r.noise_value = fbm_sum(cx, cy);
                r.is_noise = 1'b1;
            end
            default: ;
        endcase
        expected_words.push_back(r);
    endtask

    // stop sending and wait for every outstanding result
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [23:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_OCTAVE_COUNT: octaves_reg = data[4:0];
            CFG_FREQUENCY: freq_reg = data;
            CFG_AMPLITUDE: amp_reg = data;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic send_eval(logic [31:0] cx, logic [31:0] cy);
        send_word(ACT_EVAL, $urandom, $urandom, $urandom, $urandom, cx, cy);
    endtask

    // gradient with a mix of unit, in-range and raw values
    task automatic send_grad(logic [7:0] idx);
        logic [15:0] gx, gy;
        case ($urandom_range(3))
            0: begin
                gx = $urandom;
                gy = $urandom;
            end
            1: begin
                gx = $urandom_range(1) ? 16'sd16384 : -16'sd16384;
                gy = $urandom_range(1) ? 16'sd16384 : -16'sd16384;
            end
            default: begin
                gx = 16'($urandom_range(32768)) - 16'd16384;
                gy = 16'($urandom_range(32768)) - 16'd16384;
            end
        endcase
        send_word(ACT_LOAD_GRAD, idx, $urandom, gx, gy, $urandom, $urandom);
    endtask

    // every entry written before any evaluate
    task automatic test_table_fill();
        for (int e = 0; e < 256; e++) begin
            send_word(ACT_LOAD_PERM, 8'(e), $urandom, $urandom, $urandom,
                      $urandom, $urandom);
            send_grad(8'(e));
        end
    endtask

    // field extremes, spare action and out-of-range gradients at reset, then a new frequency
    task automatic test_directed();
        send_word(ACT_LOAD_GRAD, 8'd255, 8'd0, 16'h8000, 16'h7fff, '0, '0);
        send_word(ACT_LOAD_GRAD, 8'd0, 8'd255, 16'h7fff, 16'h8000, '1, '1);
        send_word(ACT_LOAD_PERM, 8'd255, 8'd255, '1, '1, '1, '1);
        send_word(ACT_LOAD_PERM, 8'd0, 8'd0, '0, '0, '0, '0);
        send_word(ACT_SPARE, 8'd17, 8'd99, '1, '1, '1, '1);
        send_word(ACT_SPARE, 8'd0, 8'd0, '0, '0, '0, '0);
        send_eval(32'h0000_0000, 32'h0000_0000);
        send_eval(32'h7fff_ffff, 32'h7fff_ffff);
        send_eval(32'h8000_0000, 32'h8000_0000);
        send_eval(32'hffff_ffff, 32'h0000_0001);
        send_eval(32'h8000_0000, 32'h7fff_ffff);
        send_eval(32'h0001_8000, 32'hfffe_8000);
        send_eval(32'h0000_ffff, 32'h0000_ffff);
        send_eval($urandom, $urandom);
        drain();
        write_reg(CFG_FREQUENCY, 24'h01_0000);
        send_eval(32'h0003_4000, 32'h0005_c000);
        send_eval(32'hfff0_0001, 32'h00ff_ffff);
        send_eval(32'h7fff_ffff, 32'h8000_0000);
    endtask

    // register extremes, saturating octave count and the unused index
    task automatic test_register_extremes();
        drain();
        write_reg(CFG_OCTAVE_COUNT, 24'd0);
        send_eval($urandom, $urandom);
        send_eval(32'h7fff_ffff, 32'h8000_0000);
        drain();
        write_reg(CFG_OCTAVE_COUNT, 24'd31);
        write_reg(CFG_FREQUENCY, 24'hff_ffff);
        write_reg(CFG_AMPLITUDE, 24'hff_ffff);
        send_eval(32'h7fff_ffff, 32'h7fff_ffff);
        send_eval(32'h8000_0000, 32'h8000_0000);
        for (int n = 0; n < 4; n++) send_eval($urandom, $urandom);
        drain();
        write_reg(CFG_UNUSED, 24'h55_aaaa);
        write_reg(CFG_OCTAVE_COUNT, 24'd16);
        write_reg(CFG_FREQUENCY, 24'd0);
        write_reg(CFG_AMPLITUDE, 24'd0);
        send_eval($urandom, $urandom);
        drain();
        write_reg(CFG_FREQUENCY, 24'h00_8000);
        write_reg(CFG_AMPLITUDE, 24'h80_0000);
        for (int n = 0; n < 24; n++) send_eval($urandom, $urandom);
    endtask

    // random evaluates and table rewrites under random settings
    task automatic test_random_mix();
        for (int p = 0; p < 6; p++) begin
            drain();
            calm = (p == 2);
            write_reg(CFG_OCTAVE_COUNT, 24'($urandom_range(1, 4)));
            write_reg(CFG_FREQUENCY, (p == 0) ? 24'h00_045a : 24'($urandom));
            write_reg(CFG_AMPLITUDE, (p == 1) ? 24'hff_ffff : 24'($urandom));
            for (int n = 0; n < 75; n++) begin
                case ($urandom_range(9))
                    0: send_word(ACT_LOAD_PERM, $urandom, $urandom, $urandom,
                                 $urandom, $urandom, $urandom);
                    1: send_grad($urandom);
                    2: send_word(ACT_SPARE, $urandom, $urandom, $urandom,
                                 $urandom, $urandom, $urandom);
                    3: send_eval(32'($urandom_range(65535)) - 32'd32768,
                                 32'($urandom_range(65535)) - 32'd32768);
                    default: send_eval($urandom, $urandom);
                endcase
            end
        end
        calm = 1'b0;
    endtask

    // result side: random stalls and comparison against the oldest expectation
    always @(posedge i_clk) begin
        t_result want;
        cycle_count <= cycle_count + 1;
        i_ready <= calm || ($urandom_range(99) >= 14);
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_words.size() == 0) begin
                $error("unexpected word: noise_value %0d is_noise %0b",
                       o_noise_value, o_is_noise);
                fail_count++;
            end else begin
                want = expected_words.pop_front();
                if (o_noise_value !== want.noise_value) begin
                    $error("noise_value expected %0d actual %0d",
                           want.noise_value, o_noise_value);
                    fail_count++;
                end
                if (o_is_noise !== want.is_noise) begin
                    $error("is_noise expected %0b actual %0b",
                           want.is_noise, o_is_noise);
                    fail_count++;
                end
            end
        end
    end

    // timeout
    always @(posedge i_clk) begin
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // test sequence
    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);
        test_table_fill();
        test_directed();
        test_register_extremes();
        test_random_mix();
        drain();
        repeat (40) @(posedge i_clk);
        if (expected_words.size() != 0) fail_count++;
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

>>> filelist.f
src/gn2f_pkg.sv
src/gn2f_ctrl.sv
src/gn2f_datapath.sv
src/gradient_noise_2d_fbm_top.sv
sim/testbench.sv
